@@ rtl/derb_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended ring buffer package
// Operation and status codes and the fixed field widths of the request and
// response transfers.
// ----------------------------------------------------------------------------
package derb_pkg;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int FILL_W   = 4;

   typedef logic [OP_W-1:0] op_code_type;

   localparam op_code_type OP_PUSH_BACK  = 3'd0;
   localparam op_code_type OP_PUSH_FRONT = 3'd1;
   localparam op_code_type OP_POP_BACK   = 3'd2;
   localparam op_code_type OP_POP_FRONT  = 3'd3;
   localparam op_code_type OP_INSERT_AT  = 3'd4;
   localparam op_code_type OP_REMOVE_AT  = 3'd5;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_BAD_POS = 2'd3
   } status_type;

endpackage

@@ rtl/derb_store.sv @@
// ----------------------------------------------------------------------------
// Double-ended ring buffer store
// Entry memory with one write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module derb_store #(
   parameter int DEPTH      = 8,
   parameter int DATA_WIDTH = 32,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/double_ended_ring_buffer.sv @@
// Sequence: push passes FINAL and DONE; pop passes FETCH, TAKE, FINAL and DONE; insert
// at adds a SHIFT_RD/SHIFT_WR pass per entry moved toward the back, remove at one per
// entry moved toward the front, as the registered-read store needs a read before each write.
// One request at a time: req_stall stays high until DONE issues the response.
// Reset: pointers and full flag clear at once, then a clearing pass zeroes every
// entry of the store while no request is taken.
// ----------------------------------------------------------------------------
// Double-ended ring buffer
// Circular deque with push/pop at both ends and insert/remove at a logical
// position, sequenced over a shared address unit and a registered-read store.
// ----------------------------------------------------------------------------
module double_ended_ring_buffer #(
   parameter int DEPTH      = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  derb_pkg::op_code_type       req_operation,
   input  logic signed [31:0]          req_value,
   input  logic [3:0]                  req_position,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output derb_pkg::status_type        rsp_status,
   output logic signed [31:0]          rsp_data_out,
   output logic [3:0]                  rsp_fill_count
);

   import derb_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_TAKE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINAL,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   op_code_type           op_ff, op_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [CW-1:0]         lim_ff, lim_in;
   status_type            status_ff, status_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [AW-1:0]         front_ff, front_in;
   logic [AW-1:0]         back_ff, back_in;
   logic                  full_ff, full_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic [3:0]            rsp_fill_ff, rsp_fill_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   logic [CW-1:0]         fill_now;
   logic [CW-1:0]         k_nb;
   logic [CW-1:0]         addr_off;
   logic [AW-1:0]         addr_phys;
   logic [AW-1:0]         front_inc, front_dec, back_inc, back_dec;
   logic [63:0]           val_ext;
   logic signed [63:0]    data_sx;
   logic [XW-1:0]         pos_x, fill_x;
   logic                  out_free;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
   endfunction

   derb_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (full_ff) begin
         fill_now = CW'(DEPTH);
      end else if (back_ff >= front_ff) begin
         fill_now = CW'(back_ff) - CW'(front_ff);
      end else begin
         fill_now = CW'(back_ff) + CW'(DEPTH) - CW'(front_ff);
      end
   end

   // shared logical-to-physical address unit
   always_comb begin
      logic [SW-1:0] sum;
      addr_off = (state_ff == ST_SHIFT_RD) ? k_nb : k_ff;
      sum = SW'(front_ff) + SW'(addr_off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      addr_phys = sum[AW-1:0];
   end

   assign k_nb      = (op_ff == OP_INSERT_AT) ? k_ff - CW'(1) : k_ff + CW'(1);
   assign front_inc = wrap_inc(front_ff);
   assign front_dec = wrap_dec(front_ff);
   assign back_inc  = wrap_inc(back_ff);
   assign back_dec  = wrap_dec(back_ff);
   assign val_ext   = {32'b0, req_value};
   assign data_sx   = 64'(signed'(data_ff));
   assign pos_x     = XW'(req_position);
   assign fill_x    = XW'(fill_now);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      k_in          = k_ff;
      lim_in        = lim_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      full_in       = full_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fill_in   = rsp_fill_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_phys;
      wr_data       = '0;
      rd_addr       = addr_phys;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               val_in    = val_ext[DATA_WIDTH-1:0];
               status_in = STATUS_OK;
               data_in   = '0;
               state_in  = ST_DONE;
               case (req_operation)
                  OP_PUSH_BACK, OP_PUSH_FRONT: begin
                     if (full_ff) begin
                        status_in = STATUS_FULL;
                     end else begin
                        state_in = ST_FINAL;
                     end
                  end
                  OP_POP_BACK: begin
                     if (fill_now == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        k_in     = fill_now - CW'(1);
                        lim_in   = fill_now - CW'(1);
                        state_in = ST_FETCH;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (fill_now == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        k_in     = '0;
                        lim_in   = '0;
                        state_in = ST_FETCH;
                     end
                  end
                  OP_INSERT_AT: begin
                     if (full_ff) begin
                        status_in = STATUS_FULL;
                     end else if (pos_x > fill_x) begin
                        status_in = STATUS_BAD_POS;
                     end else begin
                        k_in     = fill_now;
                        lim_in   = pos_x[CW-1:0];
                        state_in = (fill_x == pos_x) ? ST_FINAL : ST_SHIFT_RD;
                     end
                  end
                  OP_REMOVE_AT: begin
                     if (fill_now == '0) begin
                        status_in = STATUS_EMPTY;
                     end else if (pos_x >= fill_x) begin
                        status_in = STATUS_BAD_POS;
                     end else begin
                        k_in     = pos_x[CW-1:0];
                        lim_in   = fill_now - CW'(1);
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_TAKE;
         end
         ST_TAKE: begin
            data_in = rd_data;
            if (op_ff == OP_REMOVE_AT && k_ff != lim_ff) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            k_in     = k_nb;
            state_in = (k_nb == lim_ff) ? ST_FINAL : ST_SHIFT_RD;
         end
         ST_FINAL: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_PUSH_BACK: begin
                  wr_en   = 1'b1;
                  wr_addr = back_ff;
                  wr_data = val_ff;
                  back_in = back_inc;
                  full_in = (back_inc == front_ff);
               end
               OP_PUSH_FRONT: begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  wr_data  = val_ff;
                  front_in = front_dec;
                  full_in  = (front_dec == back_ff);
               end
               OP_POP_BACK, OP_REMOVE_AT: begin
                  wr_en   = 1'b1;
                  wr_addr = back_dec;
                  back_in = back_dec;
                  full_in = 1'b0;
               end
               OP_POP_FRONT: begin
                  front_in = front_inc;
                  full_in  = 1'b0;
               end
               OP_INSERT_AT: begin
                  wr_en   = 1'b1;
                  wr_data = val_ff;
                  back_in = back_inc;
                  full_in = (back_inc == front_ff);
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = data_sx[31:0];
               rsp_fill_in   = fill_x[3:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         front_ff     <= '0;
         back_ff      <= '0;
         full_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         full_ff      <= full_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      k_ff          <= k_in;
      lim_ff        <= lim_in;
      status_ff     <= status_in;
      data_ff       <= data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule
